/* design/cdll_pkg.sv */
// Shared definitions for the cursor linked list: operation and status codes,
// microcode program, dispatch table and the control structs between the
// sequencer and the datapath. No dependencies.
`default_nettype none

package cdll_pkg;

   // defaults for the top-level parameters
   localparam int POOL_NODES_DEF = 64;
   localparam int COORD_BITS_DEF = 16;

   // fixed field widths and stream packing
   localparam int OP_W      = 4;
   localparam int FIELD_W   = 16;
   localparam int STATUS_W  = 2;
   localparam int TDATA_W   = 40;
   localparam int REQ_X_LO  = OP_W;
   localparam int REQ_Y_LO  = OP_W + FIELD_W;
   localparam int RSP_PAD_W = TDATA_W - (2 * FIELD_W + 2 + STATUS_W);

   // operation codes
   localparam logic [OP_W-1:0] OP_HEAD      = 4'd0;
   localparam logic [OP_W-1:0] OP_TAIL      = 4'd1;
   localparam logic [OP_W-1:0] OP_PREV      = 4'd2;
   localparam logic [OP_W-1:0] OP_NEXT      = 4'd3;
   localparam logic [OP_W-1:0] OP_READ      = 4'd4;
   localparam logic [OP_W-1:0] OP_MODIFY    = 4'd5;
   localparam logic [OP_W-1:0] OP_REMOVE    = 4'd6;
   localparam logic [OP_W-1:0] OP_INS_RIGHT = 4'd7;
   localparam logic [OP_W-1:0] OP_INS_LEFT  = 4'd8;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

   // microcode actions
   localparam int ACT_W = 4;
   localparam logic [ACT_W-1:0] A_IDLE     = 4'd0;
   localparam logic [ACT_W-1:0] A_DISPATCH = 4'd1;
   localparam logic [ACT_W-1:0] A_HEAD     = 4'd2;
   localparam logic [ACT_W-1:0] A_TAIL     = 4'd3;
   localparam logic [ACT_W-1:0] A_RD_LINK  = 4'd4;
   localparam logic [ACT_W-1:0] A_GO       = 4'd5;
   localparam logic [ACT_W-1:0] A_MODIFY   = 4'd6;
   localparam logic [ACT_W-1:0] A_UNLINK   = 4'd7;
   localparam logic [ACT_W-1:0] A_ALLOC    = 4'd8;
   localparam logic [ACT_W-1:0] A_TAKE     = 4'd9;
   localparam logic [ACT_W-1:0] A_LINK_NEW = 4'd10;
   localparam logic [ACT_W-1:0] A_LINK_NBR = 4'd11;
   localparam logic [ACT_W-1:0] A_FETCH    = 4'd12;
   localparam logic [ACT_W-1:0] A_RESP     = 4'd13;

   // program addresses
   localparam int PC_W = 4;
   localparam logic [PC_W-1:0] PC_IDLE     = 4'd0;
   localparam logic [PC_W-1:0] PC_DISPATCH = 4'd1;
   localparam logic [PC_W-1:0] PC_HEAD     = 4'd2;
   localparam logic [PC_W-1:0] PC_TAIL     = 4'd3;
   localparam logic [PC_W-1:0] PC_MOVE     = 4'd4;
   localparam logic [PC_W-1:0] PC_MOVE_GO  = 4'd5;
   localparam logic [PC_W-1:0] PC_MODIFY   = 4'd6;
   localparam logic [PC_W-1:0] PC_REMOVE   = 4'd7;
   localparam logic [PC_W-1:0] PC_UNLINK   = 4'd8;
   localparam logic [PC_W-1:0] PC_ALLOC    = 4'd9;
   localparam logic [PC_W-1:0] PC_TAKE     = 4'd10;
   localparam logic [PC_W-1:0] PC_LINK_NEW = 4'd11;
   localparam logic [PC_W-1:0] PC_LINK_NBR = 4'd12;
   localparam logic [PC_W-1:0] PC_FETCH    = 4'd13;
   localparam logic [PC_W-1:0] PC_RESP     = 4'd14;

   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic             jump;    // 1: go to target, 0: fall through
      logic [PC_W-1:0]  target;
   } uword_type;

   // sequencer -> datapath
   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic             step;    // action takes effect this cycle
   } ctrl_type;

   // datapath -> sequencer
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            off;
      logic            empty;
      logic            full;
   } flags_type;

   typedef struct packed {
      logic [PC_W-1:0]     pc;
      logic [STATUS_W-1:0] status;
   } disp_type;

   // control store
   function automatic uword_type ucode(input logic [PC_W-1:0] pc);
      uword_type w;
      case (pc)
         PC_IDLE:     w = '{A_IDLE,     1'b0, PC_IDLE};
         PC_DISPATCH: w = '{A_DISPATCH, 1'b0, PC_IDLE};
         PC_HEAD:     w = '{A_HEAD,     1'b1, PC_FETCH};
         PC_TAIL:     w = '{A_TAIL,     1'b1, PC_FETCH};
         PC_MOVE:     w = '{A_RD_LINK,  1'b0, PC_IDLE};
         PC_MOVE_GO:  w = '{A_GO,       1'b1, PC_FETCH};
         PC_MODIFY:   w = '{A_MODIFY,   1'b1, PC_FETCH};
         PC_REMOVE:   w = '{A_RD_LINK,  1'b0, PC_IDLE};
         PC_UNLINK:   w = '{A_UNLINK,   1'b1, PC_FETCH};
         PC_ALLOC:    w = '{A_ALLOC,    1'b0, PC_IDLE};
         PC_TAKE:     w = '{A_TAKE,     1'b0, PC_IDLE};
         PC_LINK_NEW: w = '{A_LINK_NEW, 1'b0, PC_IDLE};
         PC_LINK_NBR: w = '{A_LINK_NBR, 1'b0, PC_IDLE};
         PC_FETCH:    w = '{A_FETCH,    1'b0, PC_IDLE};
         PC_RESP:     w = '{A_RESP,     1'b1, PC_IDLE};
         default:     w = '{A_IDLE,     1'b1, PC_IDLE};
      endcase
      return w;
   endfunction

   // entry point and status for a request
   function automatic disp_type dispatch(input flags_type f);
      disp_type d;
      d = '{PC_FETCH, ST_DONE};
      case (f.op)
         OP_HEAD: d.pc = PC_HEAD;
         OP_TAIL: d.pc = PC_TAIL;
         OP_PREV, OP_NEXT: begin
            if (f.off) d.status = ST_IGNORED;
            else       d.pc     = PC_MOVE;
         end
         OP_READ: begin
            if (f.off) d.status = ST_IGNORED;
         end
         OP_MODIFY: begin
            if (f.off) d.status = ST_IGNORED;
            else       d.pc     = PC_MODIFY;
         end
         OP_REMOVE: begin
            if (f.off) d.status = ST_IGNORED;
            else       d.pc     = PC_REMOVE;
         end
         OP_INS_RIGHT, OP_INS_LEFT: begin
            if (!f.empty && f.off) d.status = ST_IGNORED;
            else if (f.full)       d.status = ST_FULL;
            else                   d.pc     = PC_ALLOC;
         end
         default: d = '{PC_FETCH, ST_DONE};
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

/* design/cdll_sequencer.sv */
// Microcode sequencer: step counter, control store lookup and the request
// dispatch jump. Depends on cdll_pkg.
`default_nettype none

module cdll_sequencer
   import cdll_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_tvalid,
   input  wire logic      rsp_free,
   input  wire flags_type flags,
   output logic           req_tready,
   output ctrl_type       ctrl
);

   logic [PC_W-1:0] pc_ff, pc_in;
   uword_type       uword;
   disp_type        disp;

   assign uword      = ucode(pc_ff);
   assign disp       = dispatch(flags);
   assign req_tready = (uword.act == A_IDLE);

   always_comb begin
      ctrl.act  = uword.act;
      ctrl.step = 1'b1;
      pc_in     = uword.jump ? uword.target : pc_ff + 1'b1;
      case (uword.act)
         A_IDLE: begin
            ctrl.step = req_tvalid;
            if (!req_tvalid) pc_in = pc_ff;
         end
         A_DISPATCH: pc_in = disp.pc;
         A_RESP: begin
            // hold until the output register can take the response
            ctrl.step = rsp_free;
            if (!rsp_free) pc_in = pc_ff;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) pc_ff <= PC_IDLE;
      else       pc_ff <= pc_in;
   end

endmodule

`default_nettype wire

/* design/cdll_datapath.sv */
// Datapath: node and link memories, free stack, cursor and sentinel links,
// and the response register. Driven by control words from cdll_sequencer.
`default_nettype none

module cdll_datapath
   import cdll_pkg::*;
#(
   parameter int POOL_NODES = POOL_NODES_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ctrl_type           ctrl,
   input  wire logic [TDATA_W-1:0] req_tdata,
   input  wire logic               rsp_tready,
   output flags_type               flags,
   output logic                    rsp_free,
   output logic                    rsp_tvalid,
   output logic [TDATA_W-1:0]      rsp_tdata
);

   localparam int IDX_W   = $clog2(POOL_NODES);
   localparam int FRESH_W = IDX_W + 1;

   typedef logic [IDX_W-1:0]             idx_type;
   typedef logic signed [COORD_BITS-1:0] coord_type;

   // memories
   coord_type node_x_mem [POOL_NODES];
   coord_type node_y_mem [POOL_NODES];
   idx_type   pred_mem   [POOL_NODES];
   idx_type   succ_mem   [POOL_NODES];
   idx_type   stk_mem    [POOL_NODES];

   logic [OP_W-1:0]     op_ff;
   coord_type           cx_ff, cy_ff;
   idx_type             cur_ff, cur_in;
   idx_type             nbr_ff, new_ff;
   logic [STATUS_W-1:0] status_ff;
   idx_type             sent_pred_ff, sent_succ_ff;
   idx_type             stk_cnt_ff;
   logic [FRESH_W-1:0]  fresh_ff;
   logic                rd_sent_ff;
   idx_type             pred_q_ff, succ_q_ff, stk_q_ff;
   coord_type           nx_q_ff, ny_q_ff;
   logic                rsp_valid_ff;
   logic [TDATA_W-1:0]  rsp_data_ff;

   logic                is_right, do_act;
   idx_type             pred_res, succ_res, new_id;
   disp_type            disp;
   logic                pred_we, succ_we, node_we;
   idx_type             pred_wa, pred_wd, succ_wa, succ_wd, node_wa;
   logic [FIELD_W-1:0]  val_x, val_y;

   assign flags.op    = op_ff;
   assign flags.off   = (cur_ff == '0);
   assign flags.empty = (sent_pred_ff == '0);
   assign flags.full  = (stk_cnt_ff == '0) && (fresh_ff == FRESH_W'(POOL_NODES));
   assign disp        = dispatch(flags);

   assign is_right = (op_ff == OP_INS_RIGHT);
   assign do_act   = ctrl.step;

   // link read data, with the sentinel links held in registers
   assign pred_res = rd_sent_ff ? sent_pred_ff : pred_q_ff;
   assign succ_res = rd_sent_ff ? sent_succ_ff : succ_q_ff;

   // recycled nodes first, then nodes never used since reset
   assign new_id = (stk_cnt_ff != '0) ? stk_q_ff : fresh_ff[IDX_W-1:0];

   // link write ports
   always_comb begin
      pred_we = 1'b0;
      pred_wa = '0;
      pred_wd = '0;
      succ_we = 1'b0;
      succ_wa = '0;
      succ_wd = '0;
      case (ctrl.act)
         A_UNLINK: begin
            pred_we = 1'b1;
            pred_wa = succ_res;
            pred_wd = pred_res;
            succ_we = 1'b1;
            succ_wa = pred_res;
            succ_wd = succ_res;
         end
         A_LINK_NEW: begin
            pred_we = 1'b1;
            pred_wa = new_ff;
            pred_wd = is_right ? cur_ff : nbr_ff;
            succ_we = 1'b1;
            succ_wa = new_ff;
            succ_wd = is_right ? nbr_ff : cur_ff;
         end
         A_LINK_NBR: begin
            pred_we = 1'b1;
            pred_wa = is_right ? nbr_ff : cur_ff;
            pred_wd = new_ff;
            succ_we = 1'b1;
            succ_wa = is_right ? cur_ff : nbr_ff;
            succ_wd = new_ff;
         end
         default: ;
      endcase
   end

   assign node_we = (ctrl.act == A_MODIFY) || (ctrl.act == A_TAKE);
   assign node_wa = (ctrl.act == A_TAKE) ? new_id : cur_ff;

   always_ff @(posedge clock) begin
      if (pred_we && pred_wa != '0) pred_mem[pred_wa] <= pred_wd;
      if (succ_we && succ_wa != '0) succ_mem[succ_wa] <= succ_wd;
      if (node_we) begin
         node_x_mem[node_wa] <= cx_ff;
         node_y_mem[node_wa] <= cy_ff;
      end
      if (ctrl.act == A_UNLINK) stk_mem[stk_cnt_ff] <= cur_ff;

      if (ctrl.act == A_RD_LINK || ctrl.act == A_ALLOC) begin
         pred_q_ff  <= pred_mem[cur_ff];
         succ_q_ff  <= succ_mem[cur_ff];
         rd_sent_ff <= (cur_ff == '0);
      end
      if (ctrl.act == A_ALLOC) stk_q_ff <= stk_mem[stk_cnt_ff - 1'b1];
      if (ctrl.act == A_FETCH) begin
         nx_q_ff <= node_x_mem[cur_ff];
         ny_q_ff <= node_y_mem[cur_ff];
      end
   end

   // cursor
   always_comb begin
      cur_in = cur_ff;
      case (ctrl.act)
         A_HEAD:     if (sent_pred_ff != '0) cur_in = sent_succ_ff;
         A_TAIL:     if (sent_pred_ff != '0) cur_in = sent_pred_ff;
         A_GO:       cur_in = (op_ff == OP_PREV) ? pred_res : succ_res;
         A_UNLINK:   cur_in = pred_res;
         A_LINK_NBR: cur_in = new_ff;
         default:    ;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= '0;
         sent_pred_ff <= '0;
         sent_succ_ff <= '0;
         stk_cnt_ff   <= '0;
         fresh_ff     <= FRESH_W'(1);
      end else begin
         cur_ff <= cur_in;
         if (pred_we && pred_wa == '0) sent_pred_ff <= pred_wd;
         if (succ_we && succ_wa == '0) sent_succ_ff <= succ_wd;
         if (ctrl.act == A_UNLINK) stk_cnt_ff <= stk_cnt_ff + 1'b1;
         if (ctrl.act == A_TAKE) begin
            if (stk_cnt_ff != '0) stk_cnt_ff <= stk_cnt_ff - 1'b1;
            else                  fresh_ff   <= fresh_ff + 1'b1;
         end
      end
   end

   // request capture and working registers
   always_ff @(posedge clock) begin
      if (ctrl.act == A_IDLE && do_act) begin
         op_ff <= req_tdata[OP_W-1:0];
         cx_ff <= COORD_BITS'(signed'(req_tdata[REQ_X_LO +: FIELD_W]));
         cy_ff <= COORD_BITS'(signed'(req_tdata[REQ_Y_LO +: FIELD_W]));
      end
      if (ctrl.act == A_DISPATCH) status_ff <= disp.status;
      if (ctrl.act == A_TAKE) begin
         new_ff <= new_id;
         nbr_ff <= is_right ? succ_res : pred_res;
      end
   end

   // response register
   assign val_x      = flags.off ? '0 : FIELD_W'(nx_q_ff);
   assign val_y      = flags.off ? '0 : FIELD_W'(ny_q_ff);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctrl.act == A_RESP && do_act) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.act == A_RESP && do_act) begin
         rsp_data_ff <= {{RSP_PAD_W{1'b0}}, status_ff, flags.off, flags.empty, val_y, val_x};
      end
   end

endmodule

`default_nettype wire

/* design/cursor_doubly_linked_list.sv */
// Top level of the cursor linked list: joins the microcode sequencer and the
// datapath. Depends on cdll_pkg, cdll_sequencer and cdll_datapath.
//
// Usage:
//   A circular doubly linked list of (x, y) pairs with a sentinel node and a
//   cursor, kept in a pool of POOL_NODES nodes. Each request on the req_
//   stream carries one operation (head, tail, prev, next, read, modify,
//   remove, insert right, insert left) and a pair. Each request yields
//   exactly one response on the rsp_ stream: the pair under the cursor
//   afterwards (zero when the cursor sits on the sentinel), the empty and
//   off-list flags and a status (done, ignored, pool full).
//   One request is worked at a time; the sequencer returns to idle in the
//   cycle after the response is loaded and can then take the next request.
//   The number of steps per request is set by the single write port of
//   each link memory (insert rewrites two links per memory) and by the
//   registered memory reads before each use.
//   Reset makes the list empty with the cursor on the sentinel; no clearing
//   pass is needed, nodes are handed out from a fresh counter first.
//   If the receiver stalls, the response waits in the output register while
//   the next request is accepted and worked; that one waits to load its
//   response until the register is taken.
`default_nettype none

module cursor_doubly_linked_list
   import cdll_pkg::*;
#(
   parameter int POOL_NODES = POOL_NODES_DEF,
   parameter int COORD_BITS = COORD_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   // request stream
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   // [3:0] operation, [19:4] coord_x, [35:20] coord_y, [39:36] zero
   input  wire logic [TDATA_W-1:0] req_tdata,
   // response stream
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   // [15:0] value_x, [31:16] value_y, [32] list_empty, [33] off_list,
   // [35:34] status, [39:36] zero
   output logic [TDATA_W-1:0]      rsp_tdata
);

   ctrl_type  ctrl;
   flags_type flags;
   logic      rsp_free;

   cdll_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .rsp_free   (rsp_free),
      .flags      (flags),
      .req_tready (req_tready),
      .ctrl       (ctrl)
   );

   cdll_datapath #(
      .POOL_NODES (POOL_NODES),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .flags      (flags),
      .rsp_free   (rsp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

`default_nettype wire
